@@ rtl/core/csk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csk_pkg
// Shared types and constants of the count-sketch signature block.
// ----------------------------------------------------------------------------
package csk_pkg;

  // sizes
  localparam int MAX_LENGTH = 4096;
  localparam int BUCKETS    = 16;
  localparam int CNT_W      = $clog2(MAX_LENGTH);
  localparam int LEN_W      = 13;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 2 * SAMPLE_W - 1;
  localparam int SUM_W      = 28;
  localparam int NORM_W     = 43;
  localparam int SIGN_BIT   = 8;

  // depth of the hash pipe in the front
  localparam int HASH_STAGES = 5;

  // queue between hash front and accumulate back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int OCC_W  = $clog2(QDEPTH + 1);

  // reset value of the length register
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);

  // splitmix64 finaliser constants
  localparam logic [63:0] HASH_SALT   = 64'h454e50434f524553;
  localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_MIX1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_MIX2   = 64'h94d049bb133111eb;
  localparam logic [63:0] HASH_BASE   = HASH_SALT + HASH_GOLDEN;
  localparam int          SHR_A       = 30;
  localparam int          SHR_B       = 27;
  localparam int          SHR_C       = 31;

  // one classified element, as queued
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SQ_W-1:0]            sq;
    logic [BKT_W-1:0]           bucket;
    logic                       add;
    logic                       last;
  } entry_t;

endpackage

@@ rtl/core/csk_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csk_front
// Accepts samples, counts elements, hashes the index to bucket and sign.
// ----------------------------------------------------------------------------
module csk_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [csk_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csk_pkg::LEN_W-1:0]           cfg_vector_length,
  input  logic                                q_pop,
  output logic                                push,
  output csk_pkg::entry_t                     push_entry
);
  import csk_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SQ_W-1:0]            sq;
    logic                       last;
  } side_t;

  logic [LEN_W-1:0]       len_r;
  logic [CNT_W-1:0]       count_r;
  logic [OCC_W-1:0]       occ_r;
  logic [HASH_STAGES-1:0] vld_r;
  side_t                  side_r [HASH_STAGES];

  logic [63:0] mix_a_r, mix_b_r, ll1_r, ll2_r;
  logic [31:0] x1_r, x2_r;
  logic [BKT_W-1:0] bkt_r;
  logic        add_r;

  logic                 accept;
  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     count_inc;
  logic                 last_elem;
  logic [63:0]          hu, w, v, h;
  logic signed [31:0]   sq_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (occ_r < OCC_W'(QDEPTH));
  assign accept    = in_valid & in_ready;

  // effective length: zero acts as one, clamp at the maximum
  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_LENGTH)) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = len_r;
    end
  end

  assign count_inc = {1'b0, count_r} + LEN_W'(1);
  assign last_elem = (count_inc >= eff_len);

  // control: length register, element counter, credit count, stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_RESET;
      count_r <= '0;
      occ_r   <= '0;
      vld_r   <= '0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_vector_length;
      end
      if (accept) begin
        count_r <= last_elem ? '0 : count_inc[CNT_W-1:0];
      end
      occ_r <= occ_r + OCC_W'(accept) - OCC_W'(q_pop);
      vld_r <= {vld_r[HASH_STAGES-2:0], accept};
    end
  end

  // hash datapath
  assign hu      = HASH_BASE + {{(64-CNT_W){1'b0}}, count_r};
  assign sq_full = in_sample * in_sample;
  assign w       = ll1_r + {x1_r, 32'd0};
  assign v       = ll2_r + {x2_r, 32'd0};
  assign h       = v ^ (v >> SHR_C);

  always_ff @(posedge clk) begin
    // stage 1: salted index, first xor-shift, square of the sample
    mix_a_r        <= hu ^ (hu >> SHR_A);
    side_r[0].sample <= in_sample;
    side_r[0].sq     <= sq_full[SQ_W-1:0];
    side_r[0].last   <= last_elem;
    // stage 2: 64-bit product mod 2^64 as partial products
    ll1_r <= mix_a_r[31:0] * HASH_MIX1[31:0];
    x1_r  <= 32'(mix_a_r[31:0] * HASH_MIX1[63:32])
           + 32'(mix_a_r[63:32] * HASH_MIX1[31:0]);
    // stage 3: fold partial products, second xor-shift
    mix_b_r <= w ^ (w >> SHR_B);
    // stage 4: second multiply
    ll2_r <= mix_b_r[31:0] * HASH_MIX2[31:0];
    x2_r  <= 32'(mix_b_r[31:0] * HASH_MIX2[63:32])
           + 32'(mix_b_r[63:32] * HASH_MIX2[31:0]);
    // stage 5: final xor-shift, bucket and sign
    bkt_r <= h[BKT_W-1:0];
    add_r <= h[SIGN_BIT];
    for (int i = 1; i < HASH_STAGES; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign push              = vld_r[HASH_STAGES-1];
  assign push_entry.sample = side_r[HASH_STAGES-1].sample;
  assign push_entry.sq     = side_r[HASH_STAGES-1].sq;
  assign push_entry.last   = side_r[HASH_STAGES-1].last;
  assign push_entry.bucket = bkt_r;
  assign push_entry.add    = add_r;

endmodule

@@ rtl/core/csk_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csk_queue
// Short FIFO of classified words between the hash front and the back end.
// ----------------------------------------------------------------------------
module csk_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  csk_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            empty,
  output csk_pkg::entry_t head
);
  import csk_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0]  cnt_r;

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointers and fill level; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + OCC_W'(push) - OCC_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/core/csk_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csk_back
// Accumulates bucket sums, signs and norm; emits one word per bucket per run.
// ----------------------------------------------------------------------------
module csk_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  csk_pkg::entry_t                  q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csk_pkg::BKT_W-1:0]        out_bucket_index,
  output logic signed [csk_pkg::SUM_W-1:0] out_bucket_sum,
  output logic [csk_pkg::BUCKETS-1:0]      out_sign_signature,
  output logic [csk_pkg::NORM_W-1:0]       out_squared_norm,
  output logic                             out_last_of_run
);
  import csk_pkg::*;

  typedef enum logic {ST_ACC, ST_EMIT} state_t;

  state_t                   state_r;
  logic signed [SUM_W-1:0]  sums_r [BUCKETS];
  logic [BUCKETS-1:0]       sig_r;
  logic [NORM_W-1:0]        norm_r;
  logic [BKT_W-1:0]         idx_r;
  logic                     out_valid_r;
  logic [BKT_W-1:0]         out_idx_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic [BUCKETS-1:0]       out_sig_r;
  logic [NORM_W-1:0]        out_norm_r;
  logic                     out_last_r;

  logic [BKT_W-1:0]         rd_addr;
  logic signed [SUM_W-1:0]  rd_sum;
  logic signed [SUM_W-1:0]  delta;
  logic signed [SUM_W-1:0]  new_sum;
  logic                     emit_go;
  logic                     emit_last;

  // single read port: bucket under update, or bucket being reported
  assign rd_addr   = (state_r == ST_EMIT) ? idx_r : q_head.bucket;
  assign rd_sum    = sums_r[rd_addr];
  assign delta     = SUM_W'(q_head.sample);
  assign new_sum   = q_head.add ? rd_sum + delta : rd_sum - delta;

  assign q_pop     = (state_r == ST_ACC) && !q_empty;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign emit_last = (idx_r == BKT_W'(BUCKETS - 1));

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      idx_r       <= '0;
      sig_r       <= '1;
      norm_r      <= '0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        sums_r[b] <= '0;
      end
    end else begin
      // output word: loaded on emit, dropped once taken
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_ACC: begin
          if (q_pop) begin
            sums_r[q_head.bucket] <= new_sum;
            sig_r[q_head.bucket]  <= ~new_sum[SUM_W-1];
            norm_r                <= norm_r + NORM_W'(q_head.sq);
            if (q_head.last) begin
              idx_r   <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            idx_r <= idx_r + BKT_W'(1);
            // last bucket reported: clear for the next vector
            if (emit_last) begin
              sig_r   <= '1;
              norm_r  <= '0;
              state_r <= ST_ACC;
              for (int b = 0; b < BUCKETS; b++) begin
                sums_r[b] <= '0;
              end
            end
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_idx_r  <= idx_r;
      out_sum_r  <= rd_sum;
      out_sig_r  <= sig_r;
      out_norm_r <= norm_r;
      out_last_r <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bucket_index   = out_idx_r;
  assign out_bucket_sum     = out_sum_r;
  assign out_sign_signature = out_sig_r;
  assign out_squared_norm   = out_norm_r;
  assign out_last_of_run    = out_last_r;

endmodule

@@ rtl/core/count_sketch_signature.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_sketch_signature
// Count-sketch of a sample stream into 16 signed buckets with squared norm.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle while the queue has room and the back end
//   accumulates, set by the single bucket update per cycle. A vector's first
//   result passes the 5-stage hash pipe, queue and back end; then 16 results,
//   one per cycle while out_ready is high. Meanwhile the back end takes no words,
//   so the 8-entry queue fills and the input stalls after at most 8 more elements.
// Reset: vector length 4096, element count, sums and norm cleared at once.
module count_sketch_signature (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [csk_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csk_pkg::LEN_W-1:0]           cfg_vector_length,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csk_pkg::BKT_W-1:0]           out_bucket_index,
  output logic signed [csk_pkg::SUM_W-1:0]    out_bucket_sum,
  output logic [csk_pkg::BUCKETS-1:0]         out_sign_signature,
  output logic [csk_pkg::NORM_W-1:0]          out_squared_norm,
  output logic                                out_last_of_run
);
  import csk_pkg::*;

  logic   push, q_pop, q_empty;
  entry_t push_entry, q_head;

  // index hashing front
  csk_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_vector_length (cfg_vector_length),
    .q_pop             (q_pop),
    .push              (push),
    .push_entry        (push_entry)
  );

  // decoupling queue
  csk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // accumulate and report
  csk_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bucket_index   (out_bucket_index),
    .out_bucket_sum     (out_bucket_sum),
    .out_sign_signature (out_sign_signature),
    .out_squared_norm   (out_squared_norm),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
